// ===== rtl/dai_pkg.sv =====
// ============================================================================
// dai_pkg: shared types and constants for the acknowledgement issue queue
// Field widths, status codes and the command/status bundles that pass
// between the sequencer and the datapath.
// ============================================================================
package dai_pkg;

    localparam int ID_W = 32;   // event identifier
    localparam int ST_W = 3;    // status code
    localparam int PC_W = 7;    // reported pending count
    localparam int IC_W = 4;    // reported in-flight count

    localparam logic [ST_W-1:0] ST_QUEUED  = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP     = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
    localparam logic [ST_W-1:0] ST_MATCHED = 3'd3;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd4;

    localparam logic OP_REQUEST  = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    typedef struct packed {
        logic load;       // capture the input transfer, clear search flags
        logic inf_step;   // compare one in-flight entry
        logic pend_step;  // read/compare one pending entry
        logic decide;     // apply the request or completion
        logic issue_rd;   // read the queue head, pick a free slot
        logic issue_wr;   // move the head into flight
        logic out_load;   // fill the output register
    } t_dp_cmd;

    typedef struct packed {
        logic op;         // captured operation
        logic inf_last;   // in-flight scan at its last entry
        logic pend_done;  // pending scan finished
        logic can_issue;  // queue not empty and a slot is free
        logic out_free;   // output register can take a result
    } t_dp_sts;

endpackage

// ===== rtl/dai_if.sv =====
// ============================================================================
// dai_in_if / dai_out_if: valid/ready channels of the issue queue
// Input carries operation and event id; output carries one result per item.
// ============================================================================
interface dai_in_if import dai_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            operation;
    logic [ID_W-1:0] event_id;

    modport source (output valid, output operation, output event_id, input ready);
    modport sink   (input valid, input operation, input event_id, output ready);
endinterface

interface dai_out_if import dai_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic            issued_valid;
    logic [ID_W-1:0] issued_id;
    logic [PC_W-1:0] pending_count;
    logic [IC_W-1:0] inflight_count;

    modport source (output valid, output status, output issued_valid, output issued_id,
                    output pending_count, output inflight_count, input ready);
    modport sink   (input valid, input status, input issued_valid, input issued_id,
                    input pending_count, input inflight_count, output ready);
endinterface

// ===== rtl/dai_ram.sv =====
// ============================================================================
// dai_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
module dai_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== rtl/dai_ctrl.sv =====
// ============================================================================
// dai_ctrl: sequencer of the issue queue
// Steps one item through in-flight scan, pending scan (requests only), update,
// issue and result hand-off.
// ============================================================================
module dai_ctrl import dai_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SINF   = 7'b0000010,
        S_SPEND  = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_IRD    = 7'b0010000,
        S_IWR    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SINF;
                end
            end
            S_SINF: begin
                o_cmd.inf_step = 1'b1;
                if (i_sts.inf_last) begin
                    n_state = (i_sts.op == OP_REQUEST) ? S_SPEND : S_DECIDE;
                end
            end
            S_SPEND: begin
                o_cmd.pend_step = 1'b1;
                if (i_sts.pend_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_IRD;
            end
            S_IRD: begin
                // skip the move when the queue is empty or every slot is busy
                if (i_sts.can_issue) begin
                    o_cmd.issue_rd = 1'b1;
                    n_state        = S_IWR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_IWR: begin
                o_cmd.issue_wr = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/dai_dp.sv =====
// ============================================================================
// dai_dp: datapath of the issue queue
// Pending ring in RAM, in-flight slot registers, search flags, counters and
// the output register.
// ============================================================================
module dai_dp import dai_pkg::*; #(
    parameter int MAX_INFLIGHT  = 8,
    parameter int PENDING_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_dp_cmd         i_cmd,
    output t_dp_sts         o_sts,
    input  logic            i_operation,
    input  logic [ID_W-1:0] i_event_id,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [ST_W-1:0] o_status,
    output logic            o_issued_valid,
    output logic [ID_W-1:0] o_issued_id,
    output logic [PC_W-1:0] o_pending_count,
    output logic [IC_W-1:0] o_inflight_count
);

    localparam int AW = $clog2(PENDING_DEPTH);
    localparam int UW = $clog2(PENDING_DEPTH + 1);
    localparam int IW = (MAX_INFLIGHT > 1) ? $clog2(MAX_INFLIGHT) : 1;
    localparam int CW = $clog2(MAX_INFLIGHT + 1);

    // head + offset wrapped into the ring; the sum stays below twice the depth
    function automatic logic [AW-1:0] ring(input logic [AW-1:0] head,
                                           input logic [UW-1:0] off);
        logic [UW:0] sum;
        sum = (UW+1)'(head) + (UW+1)'(off);
        if (sum >= (UW+1)'(PENDING_DEPTH)) begin
            sum = sum - (UW+1)'(PENDING_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // control state
    logic [AW-1:0]           r_head;
    logic [UW-1:0]           r_used;
    logic [MAX_INFLIGHT-1:0] r_inf_vld;
    logic [CW-1:0]           r_inf_cnt;
    logic                    r_o_valid;

    // payload
    logic [ID_W-1:0] r_inf_ids [MAX_INFLIGHT];
    logic            r_op;
    logic [ID_W-1:0] r_id;
    logic [CW-1:0]   r_icnt;
    logic            r_hit_inf;
    logic            r_hit_pend;
    logic [IW-1:0]   r_slot;
    logic [UW-1:0]   r_k;
    logic            r_cmp_vld;
    logic [ST_W-1:0] r_status;
    logic            r_iss_vld;
    logic [ID_W-1:0] r_iss_id;
    logic [IW-1:0]   r_free;
    logic [ST_W-1:0] r_o_status;
    logic            r_o_iss_vld;
    logic [ID_W-1:0] r_o_iss_id;
    logic [PC_W-1:0] r_o_pcnt;
    logic [IC_W-1:0] r_o_icnt;

    logic [IW-1:0]   inf_idx;
    logic            inf_match;
    logic            pend_more;
    logic            pend_match;
    logic            is_dup;
    logic            is_full;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [ID_W-1:0] ram_rdata;
    logic [IW-1:0]   free_slot;

    assign inf_idx    = r_icnt[IW-1:0];
    assign inf_match  = r_inf_vld[inf_idx] && (r_inf_ids[inf_idx] == r_id);
    assign pend_more  = (r_k < r_used);
    assign pend_match = r_cmp_vld && (ram_rdata == r_id);
    assign is_dup     = r_hit_inf || r_hit_pend;
    assign is_full    = (r_used == UW'(PENDING_DEPTH));

    assign ram_we    = i_cmd.decide && (r_op == OP_REQUEST) && !is_dup && !is_full;
    assign ram_waddr = ring(r_head, r_used);
    assign ram_raddr = i_cmd.issue_rd ? r_head : ring(r_head, r_k);

    // lowest free slot wins
    always_comb begin
        free_slot = '0;
        for (int i = MAX_INFLIGHT - 1; i >= 0; i--) begin
            if (!r_inf_vld[i]) begin
                free_slot = IW'(i);
            end
        end
    end

    dai_ram #(
        .WIDTH (ID_W),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_id),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_used    <= '0;
            r_inf_vld <= '0;
            r_inf_cnt <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.decide) begin
                if (ram_we) begin
                    r_used <= r_used + 1'b1;
                end
                if (r_op == OP_COMPLETE && r_hit_inf) begin
                    r_inf_vld[r_slot] <= 1'b0;
                    r_inf_cnt         <= r_inf_cnt - 1'b1;
                end
            end
            if (i_cmd.issue_wr) begin
                r_inf_vld[r_free] <= 1'b1;
                r_inf_cnt         <= r_inf_cnt + 1'b1;
                r_head            <= ring(r_head, UW'(1));
                r_used            <= r_used - 1'b1;
            end
            // a new result replaces the old one only once that one is gone
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_operation;
            r_id       <= i_event_id;
            r_icnt     <= '0;
            r_hit_inf  <= 1'b0;
            r_hit_pend <= 1'b0;
            r_k        <= '0;
            r_cmp_vld  <= 1'b0;
        end
        if (i_cmd.inf_step) begin
            r_icnt <= r_icnt + 1'b1;
            if (inf_match && !r_hit_inf) begin
                r_hit_inf <= 1'b1;
                r_slot    <= inf_idx;
            end
        end
        if (i_cmd.pend_step) begin
            r_cmp_vld <= pend_more;
            if (pend_more) begin
                r_k <= r_k + 1'b1;
            end
            if (pend_match) begin
                r_hit_pend <= 1'b1;
            end
        end
        if (i_cmd.decide) begin
            r_iss_vld <= 1'b0;
            r_iss_id  <= '0;
            if (r_op == OP_REQUEST) begin
                if (is_dup) begin
                    r_status <= ST_DUP;
                end else if (is_full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_QUEUED;
                end
            end else begin
                r_status <= r_hit_inf ? ST_MATCHED : ST_UNKNOWN;
            end
        end
        if (i_cmd.issue_rd) begin
            r_free <= free_slot;
        end
        if (i_cmd.issue_wr) begin
            r_inf_ids[r_free] <= ram_rdata;
            r_iss_vld         <= 1'b1;
            r_iss_id          <= ram_rdata;
        end
        if (i_cmd.out_load) begin
            r_o_status  <= r_status;
            r_o_iss_vld <= r_iss_vld;
            r_o_iss_id  <= r_iss_id;
            r_o_pcnt    <= PC_W'(r_used);
            r_o_icnt    <= IC_W'(r_inf_cnt);
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.inf_last  = (r_icnt == CW'(MAX_INFLIGHT - 1));
    assign o_sts.pend_done = !pend_more && !r_cmp_vld;
    assign o_sts.can_issue = (r_used != '0) && (r_inf_cnt < CW'(MAX_INFLIGHT));
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_issued_valid   = r_o_iss_vld;
    assign o_issued_id      = r_o_iss_id;
    assign o_pending_count  = r_o_pcnt;
    assign o_inflight_count = r_o_icnt;

endmodule

// ===== rtl/dedup_ack_issue_queue_unit.sv =====
// ============================================================================
// dedup_ack_issue_queue_unit: de-duplicating acknowledgement issue queue
// Each item is an acknowledge request or a completion for an event id; one
// result per item reports the outcome, any id moved into flight, and counts.
// ============================================================================
// Items are handled one at a time. A request scans the in-flight slots and
// then the ids waiting in the pending queue; a completion scans the in-flight
// slots only. The in-flight slots are scanned one per cycle and the pending
// ring one entry per cycle through the single read port of its RAM. The
// input is taken again as soon as the result sits in the output register,
// whether or not the sink has taken it yet; a result the sink has not taken
// holds the next one in its last state.
module dedup_ack_issue_queue_unit import dai_pkg::*; #(
    parameter int MAX_INFLIGHT  = 8,
    parameter int PENDING_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dai_in_if.sink     i_in,
    dai_out_if.source  o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    dai_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dai_dp #(
        .MAX_INFLIGHT  (MAX_INFLIGHT),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_operation      (i_in.operation),
        .i_event_id       (i_in.event_id),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_status         (o_out.status),
        .o_issued_valid   (o_out.issued_valid),
        .o_issued_id      (o_out.issued_id),
        .o_pending_count  (o_out.pending_count),
        .o_inflight_count (o_out.inflight_count)
    );

    assign i_in.ready = in_ready;

`ifndef ASSERT_OFF
    // one item at a time: no second transfer right after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in progress");

    // the move into flight always follows the head read
    a_issue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue_wr |-> $past(cmd.issue_rd))
        else $error("issue write without preceding head read");

    // a loaded result shows up on the output
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out.valid)
        else $error("result loaded but output not valid");

    // a result is never loaded over one the sink has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("pending result overwritten");
`endif

endmodule

// ===== tb/dai_queue_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// dai_queue_checker: result checker for the acknowledgement issue queue
// Watches both channels, keeps its own copy of the pending ring and the
// in-flight slots, works out the result of every input transfer and compares
// each output transfer field by field with the oldest result still awaited.
// ============================================================================
module dai_queue_checker import dai_pkg::*; #(
    parameter int MAX_INFLIGHT  = 8,
    parameter int PENDING_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dai_in_if    i_in_mon,
    dai_out_if   i_out_mon,
    output int   o_errors,
    output int   o_outstanding,
    output int   o_checked,
    output int   o_issued,
    output int   o_full_drops
);

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            issued_valid;
        logic [ID_W-1:0] issued_id;
        logic [PC_W-1:0] pending_count;
        logic [IC_W-1:0] inflight_count;
    } t_ack_result;

    logic [ID_W-1:0] pend_ring  [PENDING_DEPTH];
    int              pend_head;
    int              pend_used;
    logic [ID_W-1:0] flight_id  [MAX_INFLIGHT];
    bit              flight_busy[MAX_INFLIGHT];

    t_ack_result     awaited_results[$];
    int              errors     = 0;
    int              checked    = 0;
    int              issued     = 0;
    int              full_drops = 0;

    // Apply one item to the shadow state and return the result it produces.
    function automatic t_ack_result apply_ack_item(input logic op, input logic [ID_W-1:0] id);
        t_ack_result r;
        int          k;
        int          slot;
        int          busy;
        bit          known;

        r    = '0;
        slot = -1;
        for (k = 0; k < MAX_INFLIGHT; k++)
            if (slot < 0 && flight_busy[k] && flight_id[k] == id)
                slot = k;

        if (op == OP_REQUEST) begin
            known = (slot >= 0);
            for (k = 0; k < pend_used; k++)
                if (pend_ring[(pend_head + k) % PENDING_DEPTH] == id)
                    known = 1'b1;
            if (known) begin
                r.status = ST_DUP;
            end else if (pend_used >= PENDING_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pend_ring[(pend_head + pend_used) % PENDING_DEPTH] = id;
                pend_used++;
                r.status = ST_QUEUED;
            end
        end else if (slot >= 0) begin
            flight_busy[slot] = 1'b0;
            r.status = ST_MATCHED;
        end else begin
            r.status = ST_UNKNOWN;
        end

        busy = 0;
        for (k = 0; k < MAX_INFLIGHT; k++)
            if (flight_busy[k])
                busy++;

        // move the queue head into the lowest free slot
        if (pend_used > 0 && busy < MAX_INFLIGHT) begin
            slot = -1;
            for (k = 0; k < MAX_INFLIGHT; k++)
                if (slot < 0 && !flight_busy[k])
                    slot = k;
            r.issued_valid    = 1'b1;
            r.issued_id       = pend_ring[pend_head];
            flight_id[slot]   = pend_ring[pend_head];
            flight_busy[slot] = 1'b1;
            pend_head         = (pend_head + 1) % PENDING_DEPTH;
            pend_used--;
            busy++;
        end

        r.pending_count  = PC_W'(pend_used);
        r.inflight_count = IC_W'(busy);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_ack_result want;
        t_ack_result next_res;
        if (!i_rst_n) begin
            pend_head = 0;
            pend_used = 0;
            for (int k = 0; k < MAX_INFLIGHT; k++)
                flight_busy[k] = 1'b0;
            awaited_results.delete();
        end else begin
            // retire before accepting: a result always belongs to an older item
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t ns: result transfer with nothing awaited (status %0h)",
                                 $time, i_out_mon.status);
                end else begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    check_field("status",         ID_W'(want.status),
                                ID_W'(i_out_mon.status));
                    check_field("issued_valid",   ID_W'(want.issued_valid),
                                ID_W'(i_out_mon.issued_valid));
                    check_field("issued_id",      want.issued_id, i_out_mon.issued_id);
                    check_field("pending_count",  ID_W'(want.pending_count),
                                ID_W'(i_out_mon.pending_count));
                    check_field("inflight_count", ID_W'(want.inflight_count),
                                ID_W'(i_out_mon.inflight_count));
                    checked++;
                    if (want.issued_valid)
                        issued++;
                    if (want.status == ST_FULL)
                        full_drops++;
                end
            end
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1) begin
                next_res = apply_ack_item(i_in_mon.operation, i_in_mon.event_id);
                awaited_results.insert(awaited_results.size(), next_res);
            end
        end
        o_errors      <= errors;
        o_outstanding <= awaited_results.size();
        o_checked     <= checked;
        o_issued      <= issued;
        o_full_drops  <= full_drops;
    end

endmodule

// ===== tb/tb_dedup_ack_issue_queue_unit.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_dedup_ack_issue_queue_unit: testbench for the acknowledgement issue queue
// Drives directed corner items, then phases of random requests and
// completions that fill the queue, drain it and mix both, with random idle
// bursts on both channels and a long output hold-off; a separate checker
// predicts and compares every result.
// ============================================================================
module tb_dedup_ack_issue_queue_unit;
    import dai_pkg::*;

    localparam int MAX_INFLIGHT  = 8;
    localparam int PENDING_DEPTH = 64;
    localparam int CLK_PERIOD    = 4;
    localparam int LONG_HOLD     = 500;
    localparam int SETTLE_CYCLES = 2 * (MAX_INFLIGHT + PENDING_DEPTH + 6);

    logic i_clk = 1'b0;
    logic i_rst_n;

    dai_in_if  in_ch ();
    dai_out_if out_ch ();

    int fail_count;
    int outstanding;
    int checked;
    int issued;
    int full_drops;

    int              items_sent    = 0;
    bit              gaps_on       = 1'b1;
    bit              quiet         = 1'b0;
    bit              long_hold_req = 1'b0;
    logic [ID_W-1:0] issued_pool[$];   // ids seen issued and not yet completed
    logic [ID_W-1:0] recent_req[$];    // last requested ids, for duplicates

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    dedup_ack_issue_queue_unit #(
        .MAX_INFLIGHT  (MAX_INFLIGHT),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dai_queue_checker #(
        .MAX_INFLIGHT  (MAX_INFLIGHT),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_errors      (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_issued      (issued),
        .o_full_drops  (full_drops)
    );

    // learn which ids went into flight so completions can target them
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1
                && out_ch.issued_valid === 1'b1)
            issued_pool.insert(issued_pool.size(), out_ch.issued_id);
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic op, input logic [ID_W-1:0] id);
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.event_id  <= id;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        if (op == OP_REQUEST) begin
            recent_req.insert(recent_req.size(), id);
            if (recent_req.size() > 16)
                recent_req.delete(0);
        end
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // hold the input until every awaited result has been transferred
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    function automatic logic [ID_W-1:0] pick_request_id();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel >= 7 && sel <= 8 && recent_req.size() > 0)
            return recent_req[$urandom_range(0, recent_req.size() - 1)];
        if (sel == 9 && issued_pool.size() > 0)
            return issued_pool[$urandom_range(0, issued_pool.size() - 1)];
        if (sel == 6)
            return $urandom_range(0, 1) ? '1 : '0;
        return $urandom;
    endfunction

    function automatic logic [ID_W-1:0] pick_completion_id();
        int              k;
        logic [ID_W-1:0] id;
        if (issued_pool.size() > 0 && $urandom_range(0, 99) < 85) begin
            k  = $urandom_range(0, issued_pool.size() - 1);
            id = issued_pool[k];
            issued_pool.delete(k);
            return id;
        end
        return $urandom;
    endfunction

    task automatic run_phase(input int n_items, input int req_pct);
        repeat (n_items) begin
            if ($urandom_range(1, 100) <= req_pct)
                send_item(OP_REQUEST, pick_request_id());
            else
                send_item(OP_COMPLETE, pick_completion_id());
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_REQUEST;
        in_ch.event_id  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, both operations, duplicates, unknown completions
        gaps_on = 1'b0;
        send_item(OP_REQUEST,  32'h0000_0000);
        send_item(OP_REQUEST,  32'hFFFF_FFFF);
        send_item(OP_REQUEST,  32'h0000_0000);
        send_item(OP_COMPLETE, 32'h0000_0000);
        send_item(OP_COMPLETE, 32'h0000_0000);
        send_item(OP_COMPLETE, 32'hFFFF_FFFF);
        send_item(OP_COMPLETE, 32'h1234_5678);
        // fill every in-flight slot, leave two pending
        for (int n = 1; n <= MAX_INFLIGHT + 2; n++)
            send_item(OP_REQUEST, ID_W'(n));
        send_item(OP_REQUEST,  ID_W'(MAX_INFLIGHT + 2));
        send_item(OP_REQUEST,  32'd5);
        send_item(OP_COMPLETE, 32'd3);
        send_item(OP_REQUEST,  32'hAAAA_AAAA);
        send_item(OP_REQUEST,  32'h5555_5555);
        send_item(OP_COMPLETE, ID_W'(MAX_INFLIGHT + 1));
        wait_drained();
        // everything in flight or still pending is known; let completions use it
        issued_pool.delete();
        for (int n = 1; n <= MAX_INFLIGHT + 2; n++)
            if (n != 3 && n != MAX_INFLIGHT + 1)
                issued_pool.insert(issued_pool.size(), ID_W'(n));
        issued_pool.insert(issued_pool.size(), 32'hAAAA_AAAA);
        issued_pool.insert(issued_pool.size(), 32'h5555_5555);

        gaps_on = 1'b1;
        run_phase(150, 85);   // fill until the queue overflows
        run_phase(150, 20);   // drain
        run_phase(150, 50);
        long_hold_req = 1'b1; // stall results while requests keep coming
        run_phase(150, 85);
        gaps_on = 1'b0;
        run_phase(150, 20);
        gaps_on = 1'b1;
        run_phase(150, 50);
        gaps_on = 1'b0;
        quiet   = 1'b1;
        run_phase(130, 50);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests/completions, checked %0d results: %0d ids issued,",
                 items_sent, checked, issued);
        $display("%0d requests dropped on a full queue, fill/drain/mixed phases with stalls.",
                 full_drops);
        if (fail_count == 0 && outstanding == 0)
            $display("** dedup_ack_issue_queue_unit: PASSED **");
        else
            $display("** dedup_ack_issue_queue_unit: FAILED **");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timeout with %0d results still awaited", outstanding);
        $display("** dedup_ack_issue_queue_unit: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dai_pkg.sv
rtl/dai_if.sv
rtl/dai_ram.sv
rtl/dai_ctrl.sv
rtl/dai_dp.sv
rtl/dedup_ack_issue_queue_unit.sv
tb/dai_queue_checker.sv
tb/tb_dedup_ack_issue_queue_unit.sv
